[rtl/core/bsf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types, sizes and codes for the membership bitmap with find-first.
// ----------------------------------------------------------------------------
package bsf_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int WORD_BITS    = 64;
    localparam int WORD_COUNT   = (MAX_ELEMENTS + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int WORD_AW      = $clog2(WORD_COUNT);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int OP_W         = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(MAX_ELEMENTS);

    localparam logic [OP_W-1:0] OP_INSERT     = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE      = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND       = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND_FIRST = 2'd3;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_OUT_RANGE = 1'b1;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [IDX_W-1:0] element;
    } t_req;

    typedef struct packed {
        logic             status;
        logic             is_member;
        logic             first_found;
        logic [IDX_W-1:0] first_index;
        logic [CNT_W-1:0] member_count;
        logic             is_empty;
    } t_rsp;

    typedef struct packed {
        logic               we;
        logic [WORD_AW-1:0] waddr;
        t_word              wdata;
        logic               re;
        logic [WORD_AW-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] index;
    } t_ffs;

    function automatic t_ffs f_first_set(input t_word word);
        t_ffs res;
        res = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (word[i]) begin
                res.found = 1'b1;
                res.index = BIT_W'(i);
            end
        end
        return res;
    endfunction

endpackage

[rtl/core/bitmap_set_with_find_first.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_set_with_find_first
// Membership bitmap over 1024 elements with member count, insert, erase,
// find and find-first-set, stored as 16 words of 64 bits in a RAM.
//
//   channel   dir   handshake                  payload
//   req       in    i_req_valid / o_req_ready  i_req (operation, element)
//   rsp       out   o_rsp_valid / i_rsp_ready  o_rsp (status .. is_empty)
//   cfg       in    i_cfg_valid / o_cfg_ready  i_cfg_data (capacity_in_use)
//
// Insert, erase and find: accept plus one RAM read, with the write-back as
// the result is registered. Find-first scans words through the single RAM
// read port, from the element's word up to the capacity. One request is in
// flight at a time. On reset, per-word valid bits read unwritten words as
// zero. A stalled result holds in the output register and holds the request.
// ----------------------------------------------------------------------------
module bitmap_set_with_find_first (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    output logic                      o_req_ready,
    input  bsf_pkg::t_req             i_req,
    output logic                      o_rsp_valid,
    input  logic                      i_rsp_ready,
    output bsf_pkg::t_rsp             o_rsp,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [bsf_pkg::CNT_W-1:0] i_cfg_data
);
    import bsf_pkg::*;

    logic [CNT_W-1:0] r_cap;
    t_mem_req         mem;
    t_word            rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    bsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cap       (r_cap),
        .o_mem       (mem),
        .i_rdata     (rdata)
    );

    bsf_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

endmodule

[rtl/core/bsf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bsf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/bsf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_ctrl
// Read-modify-write sequencer: word valid bits, member count, word scan for
// find-first and the result register.
// ----------------------------------------------------------------------------
module bsf_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_req_valid,
    output logic                    o_req_ready,
    input  bsf_pkg::t_req           i_req,
    output logic                    o_rsp_valid,
    input  logic                    i_rsp_ready,
    output bsf_pkg::t_rsp           o_rsp,
    input  logic [bsf_pkg::CNT_W-1:0] i_cap,
    output bsf_pkg::t_mem_req       o_mem,
    input  bsf_pkg::t_word          i_rdata
);
    import bsf_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic                 r_state, n_state;
    logic [OP_W-1:0]      r_op;
    logic [IDX_W-1:0]     r_elem;
    logic [CNT_W-1:0]     r_cap;
    logic                 r_in_range;
    logic [WORD_AW-1:0]   r_word, n_word;
    logic                 r_first, n_first;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [WORD_COUNT-1:0] r_wvalid;
    logic                 r_rsp_valid;
    t_rsp                 r_rsp, n_rsp;

    logic                 req_fire;
    logic                 out_free;
    logic                 done;
    logic [CNT_W-1:0]     cap_eff;
    t_word                word;
    t_word                bit_mask;
    t_word                lo_mask;
    t_word                hi_mask;
    t_word                masked;
    t_ffs                 ffs;
    logic                 bit_val;
    logic [WORD_AW:0]     next_word;
    logic [CNT_W-BIT_W-1:0] cap_word;

    assign o_req_ready = (r_state == ST_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;
    assign out_free    = !r_rsp_valid || i_rsp_ready;
    assign cap_eff     = (i_cap > CAP_MAX) ? CAP_MAX : i_cap;

    assign word     = r_wvalid[r_word] ? i_rdata : '0;
    assign bit_mask = t_word'(1) << r_elem[BIT_W-1:0];
    assign bit_val  = |(word & bit_mask);
    assign cap_word = r_cap[CNT_W-1:BIT_W];
    assign lo_mask  = r_first ? ~(bit_mask - t_word'(1)) : '1;
    assign next_word = {1'b0, r_word} + (WORD_AW+1)'(1);

    always_comb begin
        if ({1'b0, r_word} < cap_word) begin
            hi_mask = '1;
        end else if ({1'b0, r_word} == cap_word) begin
            hi_mask = (t_word'(1) << r_cap[BIT_W-1:0]) - t_word'(1);
        end else begin
            hi_mask = '0;
        end
    end

    assign masked = word & lo_mask & hi_mask;
    assign ffs    = f_first_set(masked);

    always_comb begin
        n_state = r_state;
        n_word  = r_word;
        n_first = r_first;
        n_count = r_count;
        n_rsp   = '0;
        done    = 1'b0;
        o_mem   = '0;
        o_mem.waddr = r_word;
        o_mem.raddr = r_word;

        if (r_state == ST_IDLE) begin
            if (req_fire) begin
                o_mem.re    = 1'b1;
                o_mem.raddr = i_req.element[IDX_W-1:BIT_W];
                n_word      = i_req.element[IDX_W-1:BIT_W];
                n_first     = 1'b1;
                n_state     = ST_BUSY;
            end
        end else begin
            unique case (r_op)
                OP_INSERT: begin
                    done = 1'b1;
                    if (!r_in_range) begin
                        n_rsp.status = ST_OUT_RANGE;
                    end else if (!bit_val) begin
                        o_mem.we    = out_free;
                        o_mem.wdata = word | bit_mask;
                        n_count     = r_count + CNT_W'(1);
                    end
                end
                OP_ERASE: begin
                    done = 1'b1;
                    if (!r_in_range) begin
                        n_rsp.status = ST_OUT_RANGE;
                    end else if (bit_val) begin
                        o_mem.we    = out_free;
                        o_mem.wdata = word & ~bit_mask;
                        n_count     = r_count - CNT_W'(1);
                    end
                end
                OP_FIND: begin
                    done            = 1'b1;
                    n_rsp.is_member = r_in_range && bit_val;
                end
                OP_FIND_FIRST: begin
                    if (!r_in_range || r_count == '0) begin
                        done = 1'b1;
                    end else if (ffs.found) begin
                        done              = 1'b1;
                        n_rsp.first_found = 1'b1;
                        n_rsp.first_index = {r_word, ffs.index};
                    end else if ({next_word, BIT_W'(0)} < r_cap) begin
                        o_mem.re    = 1'b1;
                        o_mem.raddr = next_word[WORD_AW-1:0];
                        n_word      = next_word[WORD_AW-1:0];
                        n_first     = 1'b0;
                    end else begin
                        done = 1'b1;
                    end
                end
                default: done = 1'b1;
            endcase
            n_rsp.member_count = n_count;
            n_rsp.is_empty     = (n_count == '0);
            if (done) begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end else begin
                    n_count = r_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_wvalid    <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (o_mem.we) begin
                r_wvalid[r_word] <= 1'b1;
            end
            if (done && out_free) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_first <= n_first;
        if (req_fire) begin
            r_op       <= i_req.operation;
            r_elem     <= i_req.element;
            r_cap      <= cap_eff;
            r_in_range <= {1'b0, i_req.element} < cap_eff;
        end
        if (done && out_free) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

[rtl/core/bsf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bsf_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_rsp_valid,
    input logic                      i_rsp_ready,
    input bsf_pkg::t_rsp             o_rsp
);
    import bsf_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("result dropped or changed while stalled");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.is_empty == (o_rsp.member_count == '0)))
        else $error("empty flag disagrees with member count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.member_count <= CNT_W'(MAX_ELEMENTS))
        else $error("member count above capacity");

    a_fields_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> $countones({o_rsp.status, o_rsp.is_member,
                                    o_rsp.first_found}) <= 1)
        else $error("result flags from more than one operation");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp.first_found |-> o_rsp.first_index == '0)
        else $error("first index set without a find-first hit");

endmodule

bind bitmap_set_with_find_first bsf_checker u_bsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);
